/* sv/stt_pkg.sv */
// Shared types, codes and constants of the source text tokenizer.
// Used by the result channel interface and the top level; no dependencies.
package stt_pkg;

  localparam int DATA_W           = 64;
  localparam int POS_OUT_W        = 16;
  localparam int MAX_TEXT_LEN_DEF = 32;
  localparam int POS_BITS_DEF     = 16;
  localparam int KW_COUNT         = 12;

  typedef enum logic [3:0] {
    LM_IDLE     = 4'd0,
    LM_LINE     = 4'd1,
    LM_BLOCK    = 4'd2,
    LM_SKIP     = 4'd3,
    LM_NUMFIRST = 4'd4,
    LM_PREFIX   = 4'd5,
    LM_DIGITS   = 4'd6,
    LM_IDENT    = 4'd7,
    LM_STRING   = 4'd8,
    LM_ESCAPE   = 4'd9
  } lex_mode_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2
  } base_t;

  typedef enum logic [2:0] {
    SQ_IDLE = 3'd0,
    SQ_LAST = 3'd1,
    SQ_FIN  = 3'd2,
    SQ_RD   = 3'd3,
    SQ_EM   = 3'd4
  } seq_t;

  typedef enum logic [2:0] {
    KIND_CHAR   = 3'd0,
    KIND_ARROW  = 3'd1,
    KIND_KWORD  = 3'd2,
    KIND_IDENT  = 3'd3,
    KIND_STRING = 3'd4,
    KIND_EMPTY  = 3'd5,
    KIND_INT    = 3'd6,
    KIND_ERROR  = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    FLT_NONE      = 4'd0,
    FLT_BARE_CR   = 4'd1,
    FLT_STR_BREAK = 4'd2,
    FLT_ESCAPE    = 4'd3,
    FLT_TOO_BIG   = 4'd4,
    FLT_BAD_DIGIT = 4'd5,
    FLT_OPEN_CMT  = 4'd6,
    FLT_OPEN_STR  = 4'd7,
    FLT_TOO_LONG  = 4'd8
  } fault_t;

  // Keywords, left aligned, zero padded to eight characters.
  localparam logic [63:0] KW_STR [KW_COUNT] = '{
    "function", {"return", 16'h0}, {"const", 24'h0}, {"signed", 16'h0},
    "unsigned", {"void", 32'h0}, {"byte", 32'h0}, {"short", 24'h0},
    {"integer", 8'h0}, {"long", 32'h0}, {"char", 32'h0}, {"boolean", 8'h0}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd8, 4'd6, 4'd5, 4'd6, 4'd8, 4'd4, 4'd4, 4'd5, 4'd7, 4'd4, 4'd4, 4'd7
  };

endpackage

/* sv/stt_in_if.sv */
// Input channel: one source byte per beat with its end-of-text mark.
// Depends on nothing.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_text;

  modport source (output valid, source_byte, end_of_text, input ready);
  modport sink   (input valid, source_byte, end_of_text, output ready);
endinterface

/* sv/stt_out_if.sv */
// Result channel: one token item per beat.
// Depends on stt_pkg for the payload widths.
interface stt_out_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          kind;
  logic signed [stt_pkg::DATA_W-1:0]   payload;
  logic [stt_pkg::POS_OUT_W-1:0]       start_row;
  logic [stt_pkg::POS_OUT_W-1:0]       start_column;
  logic [3:0]                          fault_code;
  logic                                run_last;

  modport source (output valid, kind, payload, start_row, start_column, fault_code,
                  run_last, input ready);
  modport sink   (input valid, kind, payload, start_row, start_column, fault_code,
                  run_last, output ready);
endinterface

/* sv/source_text_tokenizer_unit.sv */
// Source text tokenizer: lexer state machine around a text store memory.
// Depends on stt_pkg, stt_in_if and stt_out_if.
// Output: a token is registered on the beat carrying its lookahead; each run character is
// read from the text store (SQ_RD), then registered (SQ_EM). Throughput: one byte per cycle
// while idle and the output is free; end of text passes SQ_LAST and SQ_FIN, holding input off.
// Reset: synchronous, active low, clears all control state; the text store needs no clearing.
module source_text_tokenizer_unit #(
  parameter int MAX_TEXT_LEN = stt_pkg::MAX_TEXT_LEN_DEF,
  parameter int POS_BITS     = stt_pkg::POS_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  stt_in_if.sink         in_ch,
  stt_out_if.source      out_ch
);

  localparam int AW  = $clog2(MAX_TEXT_LEN);
  localparam int TLW = $clog2(MAX_TEXT_LEN + 1);
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [TLW-1:0]      TL_MAX  = TLW'(MAX_TEXT_LEN);

  // ---------------- state ----------------
  stt_pkg::lex_mode_t mode_r, mode_nxt;
  stt_pkg::base_t     base_r, base_nxt;
  stt_pkg::seq_t      seq_r, seq_nxt, ret_r, ret_nxt;
  stt_pkg::kind_t     run_kind_r, run_kind_nxt;
  logic [7:0]          held_r, inb_r;
  logic                held_vld_r;
  logic [POS_BITS-1:0] row_r, row_nxt, col_r, col_nxt, trow_r, trow_nxt, tcol_r, tcol_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [6:0]          dcnt_r, dcnt_nxt;
  logic                neg_r, neg_nxt;
  logic [TLW-1:0]      tlen_r, tlen_nxt, run_idx_r, run_idx_nxt;
  logic                halted_r, halted_nxt;
  logic [stt_pkg::KW_COUNT-1:0] cand_r, cand_nxt;

  logic [7:0] mem [MAX_TEXT_LEN];
  logic [7:0] rd_data_r;

  logic                out_valid_r;
  stt_pkg::kind_t      out_kind_r;
  logic [63:0]         out_pay_r;
  logic [POS_BITS-1:0] out_row_r, out_col_r;
  stt_pkg::fault_t     out_fault_r;
  logic                out_last_r;

  // ---------------- helpers ----------------
  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h0;
    if (is_digit(c)) v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
    return v[3:0];
  endfunction
  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == '1) ? v : v + POS_ONE;
  endfunction

  // ---------------- lexer step ----------------
  logic [7:0] c, la;
  logic       la_none;
  logic       la_v_dig, la_v_id;
  logic       bn_go, ad_go, na_go, st_go, st_first, st_ident, fl_go, run_go;
  logic [7:0] sc;
  logic [TLW-1:0] st_len;
  logic [stt_pkg::KW_COUNT-1:0] cand_base;
  stt_pkg::fault_t fl_code;
  logic [POS_BITS-1:0] fl_row, fl_col;
  logic       em;
  stt_pkg::kind_t em_kind;
  logic [63:0] em_pay;
  logic [POS_BITS-1:0] em_row, em_col;
  stt_pkg::kind_t run_kind_c;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0] wr_data;
  logic       kw_hit;
  logic [3:0] kw_idx;
  logic       dig_ok, bad;
  logic [3:0] dv;

  always_comb begin
    la_v_dig = !la_none && is_digit(la);
    la_v_id  = !la_none && (is_digit(la) || is_alpha(la) || la == "_");
    mode_nxt = mode_r;   base_nxt = base_r;  row_nxt = row_r;   col_nxt = col_r;
    trow_nxt = trow_r;   tcol_nxt = tcol_r;  acc_nxt = acc_r;   dcnt_nxt = dcnt_r;
    neg_nxt  = neg_r;    tlen_nxt = tlen_r;  halted_nxt = halted_r; cand_nxt = cand_r;
    bn_go = 1'b0; ad_go = 1'b0; na_go = 1'b0; st_go = 1'b0; st_first = 1'b0;
    st_ident = 1'b0; fl_go = 1'b0; run_go = 1'b0; sc = c;
    fl_code = stt_pkg::FLT_NONE; fl_row = row_r; fl_col = col_r;
    em = 1'b0; em_kind = stt_pkg::KIND_CHAR; em_pay = 64'h0; em_row = row_r; em_col = col_r;
    run_kind_c = stt_pkg::KIND_IDENT;
    wr_en = 1'b0; wr_addr = '0; wr_data = sc;
    kw_hit = 1'b0; kw_idx = 4'h0; dig_ok = 1'b0; bad = 1'b0; dv = 4'h0;
    st_len = tlen_r; cand_base = cand_r;

    if (c == 8'h0A) begin
      row_nxt = sat_inc(row_r);
      col_nxt = POS_ONE;
    end else begin
      col_nxt = sat_inc(col_r);
    end

    unique case (mode_r)
      stt_pkg::LM_IDLE: begin
        if (c == 8'h0D && !(!la_none && la == 8'h0A)) begin
          fl_go = 1'b1; fl_code = stt_pkg::FLT_BARE_CR;
        end else if (c == 8'h0D || c == 8'h0A || c == " " || c == 8'h09 ||
                     c == 8'h0B || c == 8'h0C) begin
          // whitespace: skip
        end else begin
          trow_nxt = row_r;
          tcol_nxt = col_r;
          if (c == "/" && !la_none && la == "/") mode_nxt = stt_pkg::LM_LINE;
          else if (c == "/" && !la_none && la == "*") mode_nxt = stt_pkg::LM_BLOCK;
          else if ((c == "+" || c == "-") && la_v_dig) begin
            neg_nxt  = (c == "-");
            mode_nxt = stt_pkg::LM_NUMFIRST;
          end else if (c == "-" && !la_none && la == ">") begin
            em = 1'b1; em_kind = stt_pkg::KIND_ARROW;
            mode_nxt = stt_pkg::LM_SKIP;
          end else if (is_digit(c)) begin
            neg_nxt = 1'b0;
            bn_go   = 1'b1;
          end else if (c == "\"") begin
            tlen_nxt = '0;
            mode_nxt = stt_pkg::LM_STRING;
          end else if (is_alpha(c) || c == "_") begin
            st_go = 1'b1; st_first = 1'b1; st_ident = 1'b1;
          end else begin
            em = 1'b1; em_kind = stt_pkg::KIND_CHAR; em_pay = 64'(c);
          end
        end
      end
      stt_pkg::LM_LINE:     if (c == 8'h0A) mode_nxt = stt_pkg::LM_IDLE;
      stt_pkg::LM_BLOCK:    if (c == "*" && !la_none && la == "/") mode_nxt = stt_pkg::LM_SKIP;
      stt_pkg::LM_SKIP:     mode_nxt = stt_pkg::LM_IDLE;
      stt_pkg::LM_NUMFIRST: bn_go = 1'b1;
      stt_pkg::LM_PREFIX: begin
        mode_nxt = stt_pkg::LM_DIGITS;
        na_go    = 1'b1;
      end
      stt_pkg::LM_DIGITS:   ad_go = 1'b1;
      stt_pkg::LM_IDENT: begin
        st_go = 1'b1; st_ident = 1'b1;
      end
      stt_pkg::LM_STRING: begin
        if (c == "\"") begin
          mode_nxt = stt_pkg::LM_IDLE;
          if (tlen_r == '0) begin
            em = 1'b1; em_kind = stt_pkg::KIND_EMPTY; em_row = trow_r; em_col = tcol_r;
          end else begin
            run_go = 1'b1; run_kind_c = stt_pkg::KIND_STRING;
          end
        end else if (c == 8'h0D || c == 8'h0A) begin
          fl_go = 1'b1; fl_code = stt_pkg::FLT_STR_BREAK;
        end else if (c == "\\") begin
          mode_nxt = stt_pkg::LM_ESCAPE;
        end else begin
          st_go = 1'b1;
        end
      end
      stt_pkg::LM_ESCAPE: begin
        mode_nxt = stt_pkg::LM_STRING;
        if (c == "n") begin
          st_go = 1'b1; sc = 8'h0A;
        end else if (c == "t") begin
          st_go = 1'b1; sc = 8'h09;
        end else begin
          fl_go = 1'b1; fl_code = stt_pkg::FLT_ESCAPE;
        end
      end
      default: mode_nxt = stt_pkg::LM_IDLE;
    endcase

    // begin a number; a 0x or 0b prefix sets the base and enters LM_PREFIX, adding no digit
    if (bn_go) begin
      base_nxt = stt_pkg::BASE_DEC;
      acc_nxt  = 64'h0;
      dcnt_nxt = 7'd0;
      if (c == "0" && !la_none && (la == "x" || la == "X")) begin
        base_nxt = stt_pkg::BASE_HEX; mode_nxt = stt_pkg::LM_PREFIX;
      end else if (c == "0" && !la_none && (la == "b" || la == "B")) begin
        base_nxt = stt_pkg::BASE_BIN; mode_nxt = stt_pkg::LM_PREFIX;
      end else begin
        ad_go = 1'b1;
      end
    end

    if (ad_go) begin
      dv = digit_val(c);
      if (base_nxt == stt_pkg::BASE_DEC) begin
        acc_nxt = (acc_nxt << 3) + (acc_nxt << 1) + 64'(dv);
        na_go   = 1'b1;
      end else if (dcnt_nxt >= ((base_nxt == stt_pkg::BASE_HEX) ? 7'd16 : 7'd64)) begin
        fl_go = 1'b1; fl_code = stt_pkg::FLT_TOO_BIG; fl_row = trow_nxt; fl_col = tcol_nxt;
      end else begin
        dcnt_nxt = dcnt_nxt + 7'd1;
        acc_nxt  = (base_nxt == stt_pkg::BASE_HEX) ? ((acc_nxt << 4) | 64'(dv))
                                                  : ((acc_nxt << 1) | 64'(dv));
        na_go    = 1'b1;
      end
    end

    if (na_go) begin
      unique case (base_nxt)
        stt_pkg::BASE_HEX: dig_ok = !la_none && is_hex(la);
        stt_pkg::BASE_BIN: dig_ok = !la_none && (la == "0" || la == "1");
        default:           dig_ok = la_v_dig;
      endcase
      bad = !la_none && ((base_nxt == stt_pkg::BASE_BIN) ? (is_alpha(la) || is_digit(la))
                                                         : is_alpha(la));
      if (dig_ok) begin
        mode_nxt = stt_pkg::LM_DIGITS;
      end else if (bad) begin
        fl_go = 1'b1; fl_code = stt_pkg::FLT_BAD_DIGIT; fl_row = row_nxt; fl_col = col_nxt;
      end else begin
        em = 1'b1; em_kind = stt_pkg::KIND_INT; em_row = trow_nxt; em_col = tcol_nxt;
        em_pay = neg_nxt ? (64'h0 - acc_nxt) : acc_nxt;
        mode_nxt = stt_pkg::LM_IDLE;
      end
    end

    // append to the text store and narrow the keyword candidates
    if (st_go) begin
      if (st_first) begin
        st_len    = '0;
        cand_base = '1;
      end
      if (st_len >= TL_MAX) begin
        fl_go = 1'b1; fl_code = stt_pkg::FLT_TOO_LONG; fl_row = trow_nxt; fl_col = tcol_nxt;
      end else begin
        wr_en    = 1'b1;
        wr_addr  = st_len[AW-1:0];
        wr_data  = sc;
        tlen_nxt = st_len + TLW'(1);
        for (int k = 0; k < stt_pkg::KW_COUNT; k++) begin
          cand_nxt[k] = cand_base[k] && (st_len < TLW'(stt_pkg::KW_LEN[k])) &&
                        (sc == stt_pkg::KW_STR[k][(63 - 8 * int'(st_len[2:0])) -: 8]);
        end
        if (st_ident) begin
          if (la_v_id) begin
            mode_nxt = stt_pkg::LM_IDENT;
          end else begin
            mode_nxt = stt_pkg::LM_IDLE;
            for (int k = 0; k < stt_pkg::KW_COUNT; k++) begin
              if (cand_nxt[k] && tlen_nxt == TLW'(stt_pkg::KW_LEN[k])) begin
                kw_hit = 1'b1;
                kw_idx = 4'(k);
              end
            end
            if (kw_hit) begin
              em = 1'b1; em_kind = stt_pkg::KIND_KWORD; em_pay = 64'(kw_idx);
              em_row = trow_nxt; em_col = tcol_nxt;
            end else begin
              run_go = 1'b1; run_kind_c = stt_pkg::KIND_IDENT;
            end
          end
        end
      end
    end

    if (fl_go) begin
      em = 1'b1; em_kind = stt_pkg::KIND_ERROR; em_pay = 64'h0;
      em_row = fl_row; em_col = fl_col;
      halted_nxt = 1'b1;
      mode_nxt   = stt_pkg::LM_IDLE;
    end
  end

  // ---------------- sequencer ----------------
  logic can_out, acc_in, fire, fin, load_out, out_last_c;
  stt_pkg::kind_t  ld_kind;
  logic [63:0]     ld_pay;
  logic [POS_BITS-1:0] ld_row, ld_col;
  stt_pkg::fault_t ld_fault;

  assign can_out  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (seq_r == stt_pkg::SQ_IDLE) && can_out;
  assign acc_in   = in_ch.valid && in_ch.ready;

  always_comb begin
    c = held_r; la = in_ch.source_byte; la_none = 1'b0;
    if (seq_r == stt_pkg::SQ_LAST) begin
      c = inb_r; la_none = 1'b1;
    end
    seq_nxt = seq_r; ret_nxt = ret_r; run_kind_nxt = run_kind_r; run_idx_nxt = run_idx_r;
    fire = 1'b0; fin = 1'b0; load_out = 1'b0;
    ld_kind = em_kind; ld_pay = em_pay; ld_row = em_row; ld_col = em_col;
    ld_fault = fl_code; out_last_c = 1'b1;

    unique case (seq_r)
      stt_pkg::SQ_IDLE: begin
        if (acc_in) begin
          fire = !halted_r && held_vld_r;
          if (in_ch.end_of_text) seq_nxt = stt_pkg::SQ_LAST;
        end
      end
      stt_pkg::SQ_LAST: begin
        if (can_out) begin
          fire    = !halted_r;
          seq_nxt = stt_pkg::SQ_FIN;
        end
      end
      stt_pkg::SQ_FIN: begin
        if (can_out) begin
          fin     = 1'b1;
          seq_nxt = stt_pkg::SQ_IDLE;
          ld_kind = stt_pkg::KIND_ERROR; ld_pay = 64'h0; ld_row = trow_r; ld_col = tcol_r;
          if (!halted_r && mode_r == stt_pkg::LM_BLOCK) begin
            load_out = 1'b1; ld_fault = stt_pkg::FLT_OPEN_CMT;
          end else if (!halted_r && (mode_r == stt_pkg::LM_STRING ||
                                     mode_r == stt_pkg::LM_ESCAPE)) begin
            load_out = 1'b1; ld_fault = stt_pkg::FLT_OPEN_STR;
          end
        end
      end
      stt_pkg::SQ_RD: seq_nxt = stt_pkg::SQ_EM;
      stt_pkg::SQ_EM: begin
        ld_kind = run_kind_r; ld_pay = 64'(rd_data_r); ld_row = trow_r; ld_col = tcol_r;
        ld_fault = stt_pkg::FLT_NONE;
        out_last_c = (run_idx_r + TLW'(1) == tlen_r);
        if (can_out) begin
          load_out    = 1'b1;
          run_idx_nxt = run_idx_r + TLW'(1);
          seq_nxt     = out_last_c ? ret_r : stt_pkg::SQ_RD;
        end
      end
      default: seq_nxt = stt_pkg::SQ_IDLE;
    endcase

    if (fire) begin
      if (em) begin
        load_out = 1'b1;
        if (em_kind != stt_pkg::KIND_ERROR) ld_fault = stt_pkg::FLT_NONE;
      end
      if (run_go) begin
        ret_nxt      = seq_nxt;
        seq_nxt      = stt_pkg::SQ_RD;
        run_kind_nxt = run_kind_c;
        run_idx_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= stt_pkg::SQ_IDLE;
      ret_r <= stt_pkg::SQ_IDLE;
      run_kind_r <= stt_pkg::KIND_IDENT;
      run_idx_r <= '0;
    end else begin
      seq_r <= seq_nxt;
      ret_r <= ret_nxt;
      run_kind_r <= run_kind_nxt;
      run_idx_r <= run_idx_nxt;
    end
  end

  // lexer state: cleared by reset and at the close of each text
  always_ff @(posedge clk) begin
    if (!rst_n || fin) begin
      mode_r <= stt_pkg::LM_IDLE;  base_r <= stt_pkg::BASE_DEC;
      held_r <= 8'h0;              held_vld_r <= 1'b0;
      row_r  <= POS_ONE; col_r <= POS_ONE; trow_r <= POS_ONE; tcol_r <= POS_ONE;
      acc_r  <= 64'h0; dcnt_r <= 7'd0; neg_r <= 1'b0; tlen_r <= '0;
      halted_r <= 1'b0; cand_r <= '1;
    end else begin
      if (fire) begin
        mode_r <= mode_nxt; base_r <= base_nxt; row_r <= row_nxt; col_r <= col_nxt;
        trow_r <= trow_nxt; tcol_r <= tcol_nxt; acc_r <= acc_nxt; dcnt_r <= dcnt_nxt;
        neg_r  <= neg_nxt;  tlen_r <= tlen_nxt; halted_r <= halted_nxt; cand_r <= cand_nxt;
      end
      // hold the byte one beat as lookahead; frozen while halted
      if (acc_in && !in_ch.end_of_text && !halted_r) begin
        held_r     <= in_ch.source_byte;
        held_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) inb_r <= in_ch.source_byte;
  end

  // text store
  always_ff @(posedge clk) begin
    if (fire && wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[run_idx_r[AW-1:0]];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r  <= ld_kind;
      out_pay_r   <= ld_pay;
      out_row_r   <= ld_row;
      out_col_r   <= ld_col;
      out_fault_r <= ld_fault;
      out_last_r  <= out_last_c;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.payload      = out_pay_r;
  assign out_ch.start_row    = 16'(32'(out_row_r));
  assign out_ch.start_column = 16'(32'(out_col_r));
  assign out_ch.fault_code   = out_fault_r;
  assign out_ch.run_last     = out_last_r;

`ifndef SYNTH
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == stt_pkg::SQ_EM) |-> (tlen_r != '0))
    else $error("run emitted from an empty text store");

  a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == stt_pkg::SQ_RD) |-> (run_idx_r < tlen_r))
    else $error("run read beyond the stored text");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == stt_pkg::SQ_FIN && can_out) |=>
      (!halted_r && mode_r == stt_pkg::LM_IDLE && !held_vld_r && seq_r == stt_pkg::SQ_IDLE))
    else $error("end of text did not return the lexer to its reset state");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && seq_r == stt_pkg::SQ_IDLE) |=> !load_out || seq_r == stt_pkg::SQ_FIN)
    else $error("result produced while halted");
`endif

endmodule
